### src/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define C8_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true outside reset
`define C8_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### src/c8ie_pkg.sv
// Types, constants and opcode codes of the CHIP-8 style execute core
package c8ie_pkg;

   localparam int MEM_BYTES     = 4096;
   localparam int STACK_DEPTH   = 16;
   localparam int SCREEN_WIDTH  = 64;
   localparam int SCREEN_HEIGHT = 32;
   localparam int FONT_BYTES    = 5;

   localparam int MemAw  = $clog2(MEM_BYTES);
   localparam int StkAw  = $clog2(STACK_DEPTH);
   localparam int RowAw  = $clog2(SCREEN_HEIGHT);
   localparam int PcW    = 13;
   localparam logic [PcW-1:0] PcReset = 13'd512;

   // item kinds
   localparam logic [1:0] KIND_LOAD = 2'd0;
   localparam logic [1:0] KIND_EXEC = 2'd1;
   localparam logic [1:0] KIND_TICK = 2'd2;
   localparam logic [1:0] KIND_ROW  = 2'd3;

   // major opcodes
   localparam logic [3:0] OP_SYS  = 4'h0;
   localparam logic [3:0] OP_JP   = 4'h1;
   localparam logic [3:0] OP_CALL = 4'h2;
   localparam logic [3:0] OP_SEQ  = 4'h3;
   localparam logic [3:0] OP_SNE  = 4'h4;
   localparam logic [3:0] OP_SEQR = 4'h5;
   localparam logic [3:0] OP_LD   = 4'h6;
   localparam logic [3:0] OP_ADD  = 4'h7;
   localparam logic [3:0] OP_ALU  = 4'h8;
   localparam logic [3:0] OP_SNER = 4'h9;
   localparam logic [3:0] OP_LDI  = 4'hA;
   localparam logic [3:0] OP_JPV0 = 4'hB;
   localparam logic [3:0] OP_RND  = 4'hC;
   localparam logic [3:0] OP_DRW  = 4'hD;
   localparam logic [3:0] OP_SKP  = 4'hE;
   localparam logic [3:0] OP_MISC = 4'hF;

   localparam logic [11:0] SYS_RET  = 12'h0EE;
   localparam logic [11:0] SYS_STOP = 12'h0FD;

   // 8XY? sub functions
   localparam logic [3:0] F8_LD   = 4'h0;
   localparam logic [3:0] F8_OR   = 4'h1;
   localparam logic [3:0] F8_AND  = 4'h2;
   localparam logic [3:0] F8_XOR  = 4'h3;
   localparam logic [3:0] F8_ADD  = 4'h4;
   localparam logic [3:0] F8_SUB  = 4'h5;
   localparam logic [3:0] F8_SHR  = 4'h6;
   localparam logic [3:0] F8_SUBN = 4'h7;
   localparam logic [3:0] F8_SHL  = 4'hE;

   localparam logic [7:0] EX_SKP  = 8'h9E;
   localparam logic [7:0] EX_SKNP = 8'hA1;

   localparam logic [7:0] FX_LDDT = 8'h07;
   localparam logic [7:0] FX_WKEY = 8'h0A;
   localparam logic [7:0] FX_SDT  = 8'h15;
   localparam logic [7:0] FX_ADDI = 8'h1E;
   localparam logic [7:0] FX_FONT = 8'h29;
   localparam logic [7:0] FX_STR  = 8'h55;
   localparam logic [7:0] FX_LDR  = 8'h65;

   typedef enum logic [3:0] {
      ALU_PASS, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SUBN, ALU_SHR, ALU_SHL
   } alu_op_type;

   typedef struct packed {
      logic             we;
      logic [MemAw-1:0] addr;
      logic [7:0]       wdata;
   } mem_req_type;

   typedef struct packed {
      logic                    we;
      logic [RowAw-1:0]        addr;
      logic [SCREEN_WIDTH-1:0] wdata;
   } disp_req_type;

   typedef struct packed {
      logic wr_y;
      logic wr_x;
      logic wr_f;
   } plan_type;

endpackage

### src/c8ie_mem.sv
// Main byte memory, one port, registered read
module c8ie_mem import c8ie_pkg::*; (
   input  logic        clock,
   input  mem_req_type req,
   output logic [7:0]  rdata
);

   logic [7:0] mem [MEM_BYTES];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.addr] <= req.wdata;
      end
      rdata_ff <= mem[req.addr];
   end

   assign rdata = rdata_ff;

endmodule

### src/c8ie_disp.sv
// Display row store with per-row valid bits, registered read
module c8ie_disp import c8ie_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  disp_req_type            req,
   output logic [SCREEN_WIDTH-1:0] rdata
);

   logic [SCREEN_WIDTH-1:0]  rows [SCREEN_HEIGHT];
   logic [SCREEN_HEIGHT-1:0] vld_ff;
   logic [SCREEN_WIDTH-1:0]  rdata_ff;
   logic                     rvld_ff;

   // row contents, no reset
   always_ff @(posedge clock) begin
      if (req.we) begin
         rows[req.addr] <= req.wdata;
      end
      rdata_ff <= rows[req.addr];
   end

   // a row never written reads as blank
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         rvld_ff <= 1'b0;
      end else begin
         if (req.we) begin
            vld_ff[req.addr] <= 1'b1;
         end
         rvld_ff <= vld_ff[req.addr];
      end
   end

   assign rdata = rvld_ff ? rdata_ff : '0;

endmodule

### src/c8ie_alu.sv
// Shared 8-bit ALU: logic ops, add/sub with flag, shifts, equality
module c8ie_alu import c8ie_pkg::*; (
   input  alu_op_type  op,
   input  logic [7:0]  a,
   input  logic [7:0]  b,
   output logic [7:0]  res,
   output logic        flag,
   output logic        eq
);

   logic [8:0] sum;

   assign sum = {1'b0, a} + {1'b0, b};
   assign eq  = (a == b);

   always_comb begin
      res  = b;
      flag = 1'b0;
      case (op)
         ALU_PASS: res = b;
         ALU_OR:   res = a | b;
         ALU_AND:  res = a & b;
         ALU_XOR:  res = a ^ b;
         ALU_ADD: begin
            res  = sum[7:0];
            flag = sum[8];
         end
         ALU_SUB: begin
            res  = a - b;
            flag = (a >= b);
         end
         ALU_SUBN: begin
            res  = b - a;
            flag = (b >= a);
         end
         ALU_SHR: begin
            res  = {1'b0, b[7:1]};
            flag = b[0];
         end
         ALU_SHL: begin
            res  = {b[6:0], 1'b0};
            flag = b[7];
         end
         default: res = b;
      endcase
   end

endmodule

### src/chip8_instruction_execute.sv
// Execute: fetch (F0-F2), read Y (RY), execute, write-back (WY, WX, WF) if any; draw loops
// DRRD/DRWR per row, FX55 DUMP and FX65 LDRD/LDWR per byte; all steps go through one sequencer
// and the single memory port. Row reads pass ST_ROW. One item at a time: ready only when idle.
// Reset (synchronous): registers, display and control cleared, pc 512, LFSR 1;
// main memory and return stack are not cleared.
module chip8_instruction_execute import c8ie_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [11:0] req_address,
   input  logic [7:0]  req_data,
   input  logic [4:0]  req_key,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [12:0] rsp_program_counter,
   output logic [15:0] rsp_index_value,
   output logic [7:0]  rsp_flag_value,
   output logic [63:0] rsp_row_bits,
   output logic        rsp_halted,
   output logic [4:0]  rsp_key_wait_register,
   output logic [7:0]  rsp_delay_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_random_seed
);

`include "assert_macros.svh"

   typedef enum logic [15:0] {
      ST_IDLE  = 16'h0001,
      ST_F0    = 16'h0002,
      ST_F1    = 16'h0004,
      ST_F2    = 16'h0008,
      ST_RY    = 16'h0010,
      ST_EXEC  = 16'h0020,
      ST_WY    = 16'h0040,
      ST_WX    = 16'h0080,
      ST_WF    = 16'h0100,
      ST_DUMP  = 16'h0200,
      ST_LDRD  = 16'h0400,
      ST_LDWR  = 16'h0800,
      ST_DRRD  = 16'h1000,
      ST_DRWR  = 16'h2000,
      ST_ROW   = 16'h4000,
      ST_RESP  = 16'h8000
   } state_type;

   state_type state_ff, state_in;
   logic [PcW-1:0]   pc_ff, pc_in;
   logic [15:0]      idx_ff, idx_in;
   logic [7:0]       delay_ff, delay_in;
   logic [4:0]       keyt_ff, keyt_in;
   logic [7:0]       lfsr_ff, lfsr_in;
   logic [StkAw-1:0] lvl_ff, lvl_in;
   logic [4:0]       key_ff, key_in;
   logic [7:0]       b0_ff, b0_in, b1_ff, b1_in;
   logic [7:0]       vx_ff, vx_in, vy_ff, vy_in;
   logic [7:0]       res_ff, res_in;
   logic             rflag_ff, rflag_in;
   logic             p1ok_ff, p1ok_in;
   plan_type         plan_ff, plan_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [SCREEN_WIDTH-1:0] row_ff, row_in;

   logic [7:0]     gregs_ff [16];
   logic [PcW-1:0] stack_ff [STACK_DEPTH];

   mem_req_type  mreq;
   disp_req_type dreq;
   logic [7:0]   mem_rdata;
   logic [SCREEN_WIDTH-1:0] disp_rdata;

   logic [3:0] rf_raddr, rf_waddr;
   logic [7:0] rf_rdata, rf_wdata;
   logic       rf_we;
   logic       stk_we;

   alu_op_type alu_op;
   logic [7:0] alu_a, alu_b, alu_res;
   logic       alu_flag, alu_eq;

   logic [3:0]  xr, yr, lo, opc;
   logic [7:0]  nn;
   logic [11:0] nnn;
   logic [7:0]  lfsr_nx;
   logic [16:0] draw_i;
   logic [8:0]  draw_y;
   logic [7:0]  spr_rev;
   logic [SCREEN_WIDTH-1:0] pat;
   logic [StkAw-1:0] lvl_dn;

   c8ie_mem u_mem (
      .clock (clock),
      .req   (mreq),
      .rdata (mem_rdata)
   );

   c8ie_disp u_disp (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rdata (disp_rdata)
   );

   c8ie_alu u_alu (
      .op   (alu_op),
      .a    (alu_a),
      .b    (alu_b),
      .res  (alu_res),
      .flag (alu_flag),
      .eq   (alu_eq)
   );

   // instruction fields
   assign opc = b0_ff[7:4];
   assign xr  = b0_ff[3:0];
   assign nn  = b1_ff;
   assign yr  = b1_ff[7:4];
   assign lo  = b1_ff[3:0];
   assign nnn = {xr, b1_ff};

   assign lfsr_nx = {lfsr_ff[6:0], lfsr_ff[7] ^ lfsr_ff[5] ^ lfsr_ff[4] ^ lfsr_ff[3]};
   assign lvl_dn  = (lvl_ff != '0) ? lvl_ff - 1'b1 : '0;
   assign rf_rdata = gregs_ff[rf_raddr];

   // sprite row placement: column vx+k gets bit 7-k, clipped at the right edge
   assign draw_i = {1'b0, idx_ff} + 17'(cnt_ff[3:0]);
   assign draw_y = {1'b0, vy_ff} + 9'(cnt_ff[3:0]);
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         spr_rev[k] = mem_rdata[7-k];
      end
   end
   assign pat = SCREEN_WIDTH'(spr_rev) << vx_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      idx_in   = idx_ff;
      delay_in = delay_ff;
      keyt_in  = keyt_ff;
      lfsr_in  = lfsr_ff;
      lvl_in   = lvl_ff;
      key_in   = key_ff;
      b0_in    = b0_ff;
      b1_in    = b1_ff;
      vx_in    = vx_ff;
      vy_in    = vy_ff;
      res_in   = res_ff;
      rflag_in = rflag_ff;
      p1ok_in  = p1ok_ff;
      plan_in  = plan_ff;
      cnt_in   = cnt_ff;
      row_in   = row_ff;

      mreq       = '0;
      dreq       = '0;
      mreq.addr  = idx_ff[MemAw-1:0];
      dreq.addr  = draw_y[RowAw-1:0];
      rf_raddr   = xr;
      rf_we      = 1'b0;
      rf_waddr   = xr;
      rf_wdata   = res_ff;
      stk_we     = 1'b0;
      alu_op     = ALU_PASS;
      alu_a      = vx_ff;
      alu_b      = vy_ff;

      case (state_ff)
         ST_IDLE: begin
            mreq.addr  = req_address[MemAw-1:0];
            mreq.wdata = req_data;
            dreq.addr  = req_address[RowAw-1:0];
            if (req_valid) begin
               key_in = req_key;
               row_in = '0;
               state_in = ST_RESP;
               case (req_kind)
                  KIND_LOAD: mreq.we = 1'b1;
                  KIND_EXEC: begin
                     if (pc_ff < PcW'(MEM_BYTES)) state_in = ST_F0;
                  end
                  KIND_TICK: begin
                     if (delay_ff != 8'd0) delay_in = delay_ff - 8'd1;
                  end
                  KIND_ROW: begin
                     if (req_address < 12'(SCREEN_HEIGHT)) state_in = ST_ROW;
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_ROW: begin
            row_in   = disp_rdata;
            state_in = ST_RESP;
         end
         // opcode fetch
         ST_F0: begin
            mreq.addr = pc_ff[MemAw-1:0];
            state_in  = ST_F1;
         end
         ST_F1: begin
            b0_in     = mem_rdata;
            mreq.addr = pc_ff[MemAw-1:0] + 1'b1;
            p1ok_in   = (pc_ff + 1'b1) < PcW'(MEM_BYTES);
            state_in  = ST_F2;
         end
         ST_F2: begin
            b1_in    = p1ok_ff ? mem_rdata : 8'd0;
            pc_in    = pc_ff + 13'd2;
            rf_raddr = (opc == OP_JPV0) ? 4'd0 : xr;
            vx_in    = rf_rdata;
            state_in = ST_RY;
         end
         ST_RY: begin
            rf_raddr = yr;
            vy_in    = rf_rdata;
            state_in = ST_EXEC;
         end
         // decode and execute
         ST_EXEC: begin
            plan_in  = '0;
            state_in = ST_RESP;
            case (opc)
               OP_SYS: begin
                  if (nnn == SYS_RET) begin
                     lvl_in = lvl_dn;
                     pc_in  = stack_ff[lvl_dn];
                  end else if (nnn == SYS_STOP) begin
                     pc_in = PcW'(MEM_BYTES);
                  end
               end
               OP_JP: pc_in = {1'b0, nnn};
               OP_CALL: begin
                  stk_we = 1'b1;
                  pc_in  = {1'b0, nnn};
                  if (lvl_ff < StkAw'(STACK_DEPTH - 1)) lvl_in = lvl_ff + 1'b1;
               end
               OP_SEQ: begin
                  alu_b = nn;
                  if (alu_eq) pc_in = pc_ff + 13'd2;
               end
               OP_SNE: begin
                  alu_b = nn;
                  if (!alu_eq) pc_in = pc_ff + 13'd2;
               end
               OP_SEQR: if (alu_eq) pc_in = pc_ff + 13'd2;
               OP_SNER: if (!alu_eq) pc_in = pc_ff + 13'd2;
               OP_LD: begin
                  alu_b        = nn;
                  plan_in.wr_x = 1'b1;
               end
               OP_ADD: begin
                  alu_op       = ALU_ADD;
                  alu_b        = nn;
                  plan_in.wr_x = 1'b1;
               end
               OP_ALU: begin
                  case (lo)
                     F8_LD:  plan_in.wr_x = 1'b1;
                     F8_OR: begin
                        alu_op = ALU_OR;
                        plan_in.wr_x = 1'b1;
                     end
                     F8_AND: begin
                        alu_op = ALU_AND;
                        plan_in.wr_x = 1'b1;
                     end
                     F8_XOR: begin
                        alu_op = ALU_XOR;
                        plan_in.wr_x = 1'b1;
                     end
                     F8_ADD: begin
                        alu_op  = ALU_ADD;
                        plan_in = '{wr_y: 1'b0, wr_x: 1'b1, wr_f: 1'b1};
                     end
                     F8_SUB: begin
                        alu_op  = ALU_SUB;
                        plan_in = '{wr_y: 1'b0, wr_x: 1'b1, wr_f: 1'b1};
                     end
                     F8_SUBN: begin
                        alu_op  = ALU_SUBN;
                        plan_in = '{wr_y: 1'b0, wr_x: 1'b1, wr_f: 1'b1};
                     end
                     F8_SHR: begin
                        alu_op  = ALU_SHR;
                        plan_in = '{wr_y: 1'b1, wr_x: 1'b1, wr_f: 1'b1};
                     end
                     F8_SHL: begin
                        alu_op  = ALU_SHL;
                        plan_in = '{wr_y: 1'b1, wr_x: 1'b1, wr_f: 1'b1};
                     end
                     default: plan_in = '0;
                  endcase
               end
               OP_LDI:  idx_in = {4'd0, nnn};
               OP_JPV0: pc_in = 13'(vx_ff) + 13'(nnn);
               OP_RND: begin
                  lfsr_in      = lfsr_nx;
                  alu_op       = ALU_AND;
                  alu_a        = lfsr_nx;
                  alu_b        = nn;
                  plan_in.wr_x = 1'b1;
               end
               OP_DRW: begin
                  cnt_in  = '0;
                  plan_in = '{wr_y: 1'b0, wr_x: 1'b0, wr_f: 1'b1};
               end
               OP_SKP: begin
                  alu_b = {3'd0, key_ff};
                  if (nn == EX_SKP && alu_eq) pc_in = pc_ff + 13'd2;
                  if (nn == EX_SKNP && !alu_eq) pc_in = pc_ff + 13'd2;
               end
               OP_MISC: begin
                  cnt_in = '0;
                  case (nn)
                     FX_LDDT: begin
                        alu_b        = delay_ff;
                        plan_in.wr_x = 1'b1;
                     end
                     FX_WKEY: keyt_in  = {1'b0, xr};
                     FX_SDT:  delay_in = vx_ff;
                     FX_ADDI: idx_in   = idx_ff + 16'(vx_ff);
                     FX_FONT: idx_in   = 16'(vx_ff) * 16'(FONT_BYTES);
                     FX_STR:  state_in = ST_DUMP;
                     FX_LDR:  state_in = ST_LDRD;
                     default: plan_in  = '0;
                  endcase
               end
               default: plan_in = '0;
            endcase
            res_in   = alu_res;
            rflag_in = alu_flag;
            if (opc == OP_DRW) begin
               rflag_in = 1'b0;
               state_in = ST_DRRD;
            end else if (plan_in != '0) begin
               state_in = ST_WY;
            end
         end
         // register write-back, order y, x, flag
         ST_WY: begin
            rf_we    = plan_ff.wr_y;
            rf_waddr = yr;
            state_in = ST_WX;
         end
         ST_WX: begin
            rf_we    = plan_ff.wr_x;
            rf_waddr = xr;
            state_in = ST_WF;
         end
         ST_WF: begin
            rf_we    = plan_ff.wr_f;
            rf_waddr = 4'd15;
            rf_wdata = {7'd0, rflag_ff};
            state_in = ST_RESP;
         end
         // register dump to memory, one byte a cycle
         ST_DUMP: begin
            rf_raddr   = cnt_ff[3:0];
            mreq.wdata = rf_rdata;
            if (cnt_ff <= {1'b0, xr} && idx_ff < 16'(MEM_BYTES)) begin
               mreq.we = 1'b1;
               idx_in  = idx_ff + 16'd1;
               cnt_in  = cnt_ff + 5'd1;
            end else begin
               state_in = ST_RESP;
            end
         end
         // register load from memory
         ST_LDRD: begin
            if (cnt_ff <= {1'b0, xr} && idx_ff < 16'(MEM_BYTES)) begin
               state_in = ST_LDWR;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_LDWR: begin
            rf_we    = 1'b1;
            rf_waddr = cnt_ff[3:0];
            rf_wdata = mem_rdata;
            idx_in   = idx_ff + 16'd1;
            cnt_in   = cnt_ff + 5'd1;
            state_in = ST_LDRD;
         end
         // sprite draw: each row read (DRRD), then XORed into the display (DRWR)
         ST_DRRD: begin
            mreq.addr = draw_i[MemAw-1:0];
            if (cnt_ff[3:0] < lo && draw_i < 17'(MEM_BYTES)
                && draw_y < 9'(SCREEN_HEIGHT)) begin
               state_in = ST_DRWR;
            end else begin
               state_in = ST_WY;
            end
         end
         ST_DRWR: begin
            dreq.we    = 1'b1;
            dreq.wdata = disp_rdata ^ pat;
            rflag_in   = rflag_ff | (|(disp_rdata & pat));
            cnt_in     = cnt_ff + 5'd1;
            state_in   = ST_DRRD;
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_valid) begin
         lfsr_in = (csr_random_seed != 8'd0) ? csr_random_seed : 8'd1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= PcReset;
         idx_ff   <= '0;
         delay_ff <= '0;
         keyt_ff  <= 5'd16;
         lfsr_ff  <= 8'd1;
         lvl_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         idx_ff   <= idx_in;
         delay_ff <= delay_in;
         keyt_ff  <= keyt_in;
         lfsr_ff  <= lfsr_in;
         lvl_ff   <= lvl_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      b0_ff    <= b0_in;
      b1_ff    <= b1_in;
      vx_ff    <= vx_in;
      vy_ff    <= vy_in;
      res_ff   <= res_in;
      rflag_ff <= rflag_in;
      p1ok_ff  <= p1ok_in;
      plan_ff  <= plan_in;
      cnt_ff   <= cnt_in;
      row_ff   <= row_in;
   end

   // general registers V0..VF
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 16; r++) begin
            gregs_ff[r] <= 8'd0;
         end
      end else if (rf_we) begin
         gregs_ff[rf_waddr] <= rf_wdata;
      end
   end

   // return stack
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_ff[lvl_ff] <= pc_ff;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == ST_RESP);

   assign rsp_program_counter   = pc_ff;
   assign rsp_index_value       = idx_ff;
   assign rsp_flag_value        = gregs_ff[15];
   assign rsp_row_bits          = row_ff;
   assign rsp_halted            = (pc_ff >= PcW'(MEM_BYTES));
   assign rsp_key_wait_register = keyt_ff;
   assign rsp_delay_value       = delay_ff;

   `C8_NEVER(a_idle_vs_resp, clock, reset, req_ready && rsp_valid, "ready while result pending")
   `C8_ASSERT(a_busy_after_accept, clock, reset, (req_valid && req_ready) |=> !req_ready, "accepted twice")
   `C8_ASSERT(a_idle_after_resp, clock, reset, (rsp_valid && rsp_ready) |=> req_ready, "not idle after result")

endmodule
